### hw/rtl/alle_pkg.sv
// Shared constants, codes and types for the array linked list engine.
// Used by alle_slot_map, array_linked_list_engine_unit and the sim benches.
`timescale 1ns / 1ps

package alle_pkg;

   localparam int Depth     = 64;
   localparam int SlotW     = $clog2(Depth);
   localparam int ValW      = 32;
   localparam int ScanW     = 8;
   localparam int ScanGroups = Depth / ScanW;
   localparam int GrpW      = $clog2(ScanGroups);
   localparam int IdxW      = $clog2(ScanW);

   localparam int ReqDataW  = 48;
   localparam int RspDataW  = 40;

   localparam logic [2:0] MODE_APPEND = 3'd0;
   localparam logic [2:0] MODE_POP    = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;
   localparam logic [1:0] STAT_INVALID = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_SCAN,
      S_ANCHOR_RD,
      S_LINK_A,
      S_LINK_B,
      S_UNLINK_RD,
      S_UNLINK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             scan_start;
      logic             set_en;
      logic [SlotW-1:0] set_idx;
      logic             free_en;
      logic [SlotW-1:0] free_idx;
      logic [SlotW-1:0] query_idx;
   } map_ctrl_type;

   typedef struct packed {
      logic             scan_done;
      logic [SlotW-1:0] free_slot;
      logic             query_occ;
   } map_stat_type;

endpackage

### hw/rtl/alle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module alle_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/alle_slot_map.sv
// Slot occupancy bits and the free-slot finder, one group of bits per cycle.
// Depends on alle_pkg.
`timescale 1ns / 1ps

module alle_slot_map
   import alle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  map_ctrl_type ctrl,
   output map_stat_type stat
);

   logic [Depth-1:0] occ_ff, occ_in;
   logic [GrpW-1:0]  grp_ff, grp_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SlotW-1:0] found_ff, found_in;

   logic [ScanW-1:0] grp_bits;
   logic             hit;
   logic [IdxW-1:0]  hit_idx;

   assign grp_bits = occ_ff[grp_ff*ScanW +: ScanW];

   // lowest clear bit of the current group
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = ScanW - 1; i >= 0; i--) begin
         if (!grp_bits[i]) begin
            hit     = 1'b1;
            hit_idx = IdxW'(i);
         end
      end
   end

   always_comb begin
      occ_in   = occ_ff;
      grp_in   = grp_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      found_in = found_ff;
      if (ctrl.clear) begin
         occ_in    = '0;
         occ_in[0] = 1'b1;
      end else begin
         if (ctrl.set_en) begin
            occ_in[ctrl.set_idx] = 1'b1;
         end
         if (ctrl.free_en) begin
            occ_in[ctrl.free_idx] = 1'b0;
         end
      end
      if (ctrl.scan_start) begin
         grp_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (hit) begin
            found_in = {grp_ff, hit_idx};
            busy_in  = 1'b0;
            done_in  = 1'b1;
         end else if (grp_ff == GrpW'(ScanGroups - 1)) begin
            found_in = '0;
            busy_in  = 1'b0;
            done_in  = 1'b1;
         end else begin
            grp_in = grp_ff + GrpW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= {{(Depth-1){1'b0}}, 1'b1};
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         occ_ff    <= occ_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
      end
      grp_ff   <= grp_in;
      found_ff <= found_in;
   end

   assign stat.scan_done = done_ff;
   assign stat.free_slot = found_ff;
   assign stat.query_occ = occ_ff[ctrl.query_idx];

   sentinel_busy: assert property (@(posedge clock) disable iff (reset) occ_ff[0])
      else $error("sentinel slot lost its occupied bit");
   scan_excl: assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("scan busy and done at once");
   scan_free: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && hit && !ctrl.scan_start) |=> (done_ff && !occ_ff[found_ff]))
      else $error("scan returned an occupied slot");

endmodule

### hw/rtl/array_linked_list_engine_unit.sv
// Array linked list engine: doubly linked list in slot RAMs, slot 0 sentinel.
// Clear and rejected requests go from the check straight to the result; pop and delete read,
// then unlink; append scans for a free slot (8 slots a cycle); insert scans while it walks to its rank.
// One request at a time; a new request is taken while the previous result waits.
// Reset (synchronous): empty list, sentinel self-linked, last removed value all ones.
// Depends on alle_pkg, alle_ram, alle_slot_map.
`timescale 1ns / 1ps

module array_linked_list_engine_unit
   import alle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // value[31:0], rank[37:32], slot[43:38], zero pad
   input  logic [2:0]          req_tuser,   // mode[2:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // removed_value[31:0], used_slot[37:32], zero pad
   output logic [1:0]          rsp_tuser    // status[1:0]
);

   state_type state_ff, state_in;

   logic [2:0]       mode_ff, mode_in;
   logic [ValW-1:0]  value_ff, value_in;
   logic [SlotW-1:0] rank_ff, rank_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [SlotW-1:0] anchor_ff, anchor_in;
   logic [SlotW-1:0] remain_ff, remain_in;
   logic [SlotW-1:0] pos_ff, pos_in;
   logic [SlotW-1:0] nx_ff, nx_in;
   logic [SlotW-1:0] head_ff, head_in;
   logic [SlotW-1:0] tail_ff, tail_in;
   logic [SlotW-1:0] count_ff, count_in;
   logic [ValW-1:0]  last_ff, last_in;
   logic [1:0]       res_stat_ff, res_stat_in;
   logic [SlotW-1:0] res_used_ff, res_used_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_stat_ff, rsp_stat_in;
   logic [ValW-1:0]  rsp_val_ff, rsp_val_in;
   logic [SlotW-1:0] rsp_used_ff, rsp_used_in;

   logic             n_wr_en, p_wr_en, v_wr_en;
   logic [SlotW-1:0] n_wr_addr, p_wr_addr, v_wr_addr;
   logic [SlotW-1:0] n_wr_data, p_wr_data;
   logic [ValW-1:0]  v_wr_data;
   logic             n_rd_en, p_rd_en, v_rd_en;
   logic [SlotW-1:0] n_rd_addr, p_rd_addr, v_rd_addr;
   logic [SlotW-1:0] n_rd_data, p_rd_data;
   logic [ValW-1:0]  v_rd_data;

   map_ctrl_type map_ctrl;
   map_stat_type map_stat;

   logic req_fire, rsp_load;
   logic full_w, empty_w, rank_bad, slot_bad;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign full_w   = (count_ff == SlotW'(Depth - 1));
   assign empty_w  = (count_ff == '0);
   assign rank_bad = (rank_ff > count_ff);
   assign slot_bad = (slot_ff == '0) || ({1'b0, slot_ff} >= (SlotW+1)'(Depth))
                     || !map_stat.query_occ;

   alle_ram #(.Width(SlotW), .Depth(Depth)) u_next_ram (
      .clock  (clock),
      .wr_en  (n_wr_en),
      .wr_addr(n_wr_addr),
      .wr_data(n_wr_data),
      .rd_en  (n_rd_en),
      .rd_addr(n_rd_addr),
      .rd_data(n_rd_data)
   );

   alle_ram #(.Width(SlotW), .Depth(Depth)) u_prev_ram (
      .clock  (clock),
      .wr_en  (p_wr_en),
      .wr_addr(p_wr_addr),
      .wr_data(p_wr_data),
      .rd_en  (p_rd_en),
      .rd_addr(p_rd_addr),
      .rd_data(p_rd_data)
   );

   alle_ram #(.Width(ValW), .Depth(Depth)) u_value_ram (
      .clock  (clock),
      .wr_en  (v_wr_en),
      .wr_addr(v_wr_addr),
      .wr_data(v_wr_data),
      .rd_en  (v_rd_en),
      .rd_addr(v_rd_addr),
      .rd_data(v_rd_data)
   );

   alle_slot_map u_slot_map (
      .clock(clock),
      .reset(reset),
      .ctrl (map_ctrl),
      .stat (map_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_CHECK;
         end
         S_CHECK: begin
            unique case (mode_ff)
               MODE_APPEND: state_in = full_w ? S_DONE : S_SCAN;
               MODE_INSERT: begin
                  if (full_w || rank_bad) state_in = S_DONE;
                  else if (rank_ff == '0) state_in = S_SCAN;
                  else state_in = S_WALK;
               end
               MODE_POP:    state_in = empty_w ? S_DONE : S_UNLINK_RD;
               MODE_DELETE: state_in = (empty_w || slot_bad) ? S_DONE : S_UNLINK_RD;
               default:     state_in = S_DONE;
            endcase
         end
         S_WALK: begin
            if (remain_ff == '0) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (map_stat.scan_done) state_in = S_ANCHOR_RD;
         end
         S_ANCHOR_RD: state_in = S_LINK_A;
         S_LINK_A:    state_in = S_LINK_B;
         S_LINK_B:    state_in = S_DONE;
         S_UNLINK_RD: state_in = S_UNLINK;
         S_UNLINK:    state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mode_in     = mode_ff;
      value_in    = value_ff;
      rank_in     = rank_ff;
      slot_in     = slot_ff;
      anchor_in   = anchor_ff;
      remain_in   = remain_ff;
      pos_in      = pos_ff;
      nx_in       = nx_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      res_stat_in = res_stat_ff;
      res_used_in = res_used_ff;
      rsp_stat_in = rsp_stat_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_used_in = rsp_used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready  = 1'b0;

      n_wr_en = 1'b0;  n_wr_addr = pos_ff;  n_wr_data = '0;
      p_wr_en = 1'b0;  p_wr_addr = pos_ff;  p_wr_data = '0;
      v_wr_en = 1'b0;  v_wr_addr = pos_ff;  v_wr_data = value_ff;
      n_rd_en = 1'b0;  n_rd_addr = pos_ff;
      p_rd_en = 1'b0;  p_rd_addr = pos_ff;
      v_rd_en = 1'b0;  v_rd_addr = pos_ff;

      map_ctrl            = '0;
      map_ctrl.set_idx    = pos_ff;
      map_ctrl.free_idx   = pos_ff;
      map_ctrl.query_idx  = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               mode_in  = req_tuser;
               value_in = req_tdata[ValW-1:0];
               rank_in  = req_tdata[32 +: SlotW];
               slot_in  = req_tdata[38 +: SlotW];
            end
         end
         S_CHECK: begin
            res_stat_in = STAT_OK;
            res_used_in = '0;
            unique case (mode_ff)
               MODE_APPEND: begin
                  if (full_w) begin
                     res_stat_in = STAT_FULL;
                  end else begin
                     anchor_in           = tail_ff;
                     map_ctrl.scan_start = 1'b1;
                  end
               end
               MODE_INSERT: begin
                  if (full_w) begin
                     res_stat_in = STAT_FULL;
                  end else if (rank_bad) begin
                     res_stat_in = STAT_INVALID;
                  end else begin
                     map_ctrl.scan_start = 1'b1;
                     anchor_in = (rank_ff == '0) ? '0 : head_ff;
                     remain_in = rank_ff - SlotW'(1);
                     n_rd_en   = 1'b1;
                     n_rd_addr = head_ff;
                  end
               end
               MODE_POP: begin
                  if (empty_w) res_stat_in = STAT_EMPTY;
                  else pos_in = tail_ff;
               end
               MODE_DELETE: begin
                  if (empty_w) res_stat_in = STAT_EMPTY;
                  else if (slot_bad) res_stat_in = STAT_INVALID;
                  else pos_in = slot_ff;
               end
               MODE_CLEAR: begin
                  map_ctrl.clear = 1'b1;
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
                  last_in  = '1;
               end
               default: res_stat_in = STAT_INVALID;
            endcase
         end
         S_WALK: begin
            // the walk never revisits the sentinel, so every hop is a RAM read
            if (remain_ff != '0) begin
               anchor_in = n_rd_data;
               n_rd_en   = 1'b1;
               n_rd_addr = n_rd_data;
               remain_in = remain_ff - SlotW'(1);
            end
         end
         S_SCAN: begin
            if (map_stat.scan_done) pos_in = map_stat.free_slot;
         end
         S_ANCHOR_RD: begin
            n_rd_en   = (anchor_ff != '0);
            n_rd_addr = anchor_ff;
         end
         S_LINK_A: begin
            nx_in     = (anchor_ff == '0) ? head_ff : n_rd_data;
            v_wr_en   = 1'b1;
            n_wr_en   = 1'b1;
            n_wr_data = (anchor_ff == '0) ? head_ff : n_rd_data;
            p_wr_en   = 1'b1;
            p_wr_data = anchor_ff;
         end
         S_LINK_B: begin
            if (nx_ff == '0) begin
               tail_in = pos_ff;
            end else begin
               p_wr_en   = 1'b1;
               p_wr_addr = nx_ff;
               p_wr_data = pos_ff;
            end
            if (anchor_ff == '0) begin
               head_in = pos_ff;
            end else begin
               n_wr_en   = 1'b1;
               n_wr_addr = anchor_ff;
               n_wr_data = pos_ff;
            end
            map_ctrl.set_en = 1'b1;
            count_in    = count_ff + SlotW'(1);
            res_used_in = pos_ff;
         end
         S_UNLINK_RD: begin
            n_rd_en = 1'b1;
            p_rd_en = 1'b1;
            v_rd_en = 1'b1;
         end
         S_UNLINK: begin
            if (p_rd_data == '0) begin
               head_in = n_rd_data;
            end else begin
               n_wr_en   = 1'b1;
               n_wr_addr = p_rd_data;
               n_wr_data = n_rd_data;
            end
            if (n_rd_data == '0) begin
               tail_in = p_rd_data;
            end else begin
               p_wr_en   = 1'b1;
               p_wr_addr = n_rd_data;
               p_wr_data = p_rd_data;
            end
            last_in          = v_rd_data;
            map_ctrl.free_en = 1'b1;
            count_in    = count_ff - SlotW'(1);
            res_used_in = pos_ff;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_val_in   = last_ff;
               rsp_used_in  = res_used_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         last_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      rank_ff     <= rank_in;
      slot_ff     <= slot_in;
      anchor_ff   <= anchor_in;
      remain_ff   <= remain_in;
      pos_ff      <= pos_in;
      nx_ff       <= nx_in;
      res_stat_ff <= res_stat_in;
      res_used_ff <= res_used_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {{(RspDataW - ValW - SlotW){1'b0}}, rsp_used_ff, rsp_val_ff};

   empty_links: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list with sentinel not self-linked");
   nonempty_links: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (head_ff != '0 && tail_ff != '0))
      else $error("non-empty list with sentinel link");
   scan_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff != SlotW'(Depth - 1)))
      else $error("slot search on a full list");
   accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_CHECK))
      else $error("accepted transaction not decoded");

endmodule

### sim/alle_list_checker.sv
`timescale 1ns / 1ps
// Checker for array_linked_list_engine_unit: watches the request and response streams,
// keeps a shadow slot list, predicts each reply and compares it. Depends on alle_pkg.

module alle_list_checker
   import alle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic [2:0]          req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   output int                  fail_count,
   output int                  pending_count,
   output logic [Depth-1:0]    live_slots,
   output int                  live_count,
   output int                  ok_seen,
   output int                  full_seen,
   output int                  empty_seen,
   output int                  invalid_seen
);

   typedef struct packed {
      logic [1:0]       status;
      logic [ValW-1:0]  removed;
      logic [SlotW-1:0] used;
   } list_reply_type;

   logic [ValW-1:0]  slot_val [Depth];
   logic [SlotW-1:0] fwd      [Depth];
   logic [SlotW-1:0] bwd      [Depth];
   logic [ValW-1:0]  last_value;
   list_reply_type   pending_replies [$];

   // empty list: sentinel linked to itself, nothing removed yet
   function automatic void drop_links();
      for (int i = 0; i < Depth; i++) begin
         fwd[i] = '0;
         bwd[i] = '0;
      end
      live_slots    = '0;
      live_slots[0] = 1'b1;
      live_count    = 0;
      last_value    = '1;
   endfunction

   function automatic logic [SlotW-1:0] lowest_free();
      for (int i = 1; i < Depth; i++) begin
         if (!live_slots[i]) return SlotW'(i);
      end
      return '0;
   endfunction

   function automatic void link_after(input logic [SlotW-1:0] anchor,
                                      input logic [SlotW-1:0] pos,
                                      input logic [ValW-1:0]  v);
      logic [SlotW-1:0] nx;
      nx              = fwd[anchor];
      slot_val[pos]   = v;
      live_slots[pos] = 1'b1;
      fwd[pos]        = nx;
      bwd[pos]        = anchor;
      bwd[nx]         = pos;
      fwd[anchor]     = pos;
      live_count++;
   endfunction

   function automatic void unlink_slot(input logic [SlotW-1:0] pos);
      logic [SlotW-1:0] nx;
      logic [SlotW-1:0] pv;
      nx              = fwd[pos];
      pv              = bwd[pos];
      last_value      = slot_val[pos];
      fwd[pv]         = nx;
      bwd[nx]         = pv;
      fwd[pos]        = '0;
      bwd[pos]        = '0;
      live_slots[pos] = 1'b0;
      live_count--;
   endfunction

   function automatic list_reply_type run_list_op(input logic [2:0]       mode,
                                                  input logic [ValW-1:0]  v,
                                                  input logic [SlotW-1:0] rank,
                                                  input logic [SlotW-1:0] slot);
      list_reply_type   r;
      logic [SlotW-1:0] pos;
      logic [SlotW-1:0] anchor;
      logic             full;
      r.status = STAT_OK;
      r.used   = '0;
      full     = (live_count >= Depth - 1);
      case (mode)
         MODE_APPEND: begin
            if (full) begin
               r.status = STAT_FULL;
            end else begin
               pos = lowest_free();
               link_after(bwd[0], pos, v);
               r.used = pos;
            end
         end
         MODE_POP: begin
            if (live_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               pos = bwd[0];
               unlink_slot(pos);
               r.used = pos;
            end
         end
         MODE_INSERT: begin
            // full takes priority over a bad rank
            if (full) begin
               r.status = STAT_FULL;
            end else if (int'(rank) > live_count) begin
               r.status = STAT_INVALID;
            end else begin
               anchor = '0;
               for (int i = 0; i < int'(rank); i++) anchor = fwd[anchor];
               pos = lowest_free();
               link_after(anchor, pos, v);
               r.used = pos;
            end
         end
         MODE_DELETE: begin
            // empty takes priority over a bad slot
            if (live_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (slot == '0 || !live_slots[slot]) begin
               r.status = STAT_INVALID;
            end else begin
               unlink_slot(slot);
               r.used = slot;
            end
         end
         MODE_CLEAR: begin
            drop_links();
         end
         default: begin
            r.status = STAT_INVALID;
         end
      endcase
      r.removed = last_value;
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got;
      if (reset) begin
         drop_links();
         pending_replies.delete();
      end else begin
         // reply side first; a request taken on the same edge cannot be answered yet
         if (rsp_tvalid && rsp_tready) begin
            got.status  = rsp_tuser;
            got.removed = rsp_tdata[ValW-1:0];
            got.used    = rsp_tdata[ValW +: SlotW];
            if (pending_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected reply status %0d removed %h slot %0d",
                           $realtime, got.status, got.removed, got.used);
            end else begin
               want = pending_replies.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected status %0d removed %h slot %0d,",
                               " got status %0d removed %h slot %0d"},
                              $realtime, want.status, want.removed, want.used,
                              got.status, got.removed, got.used);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = run_list_op(req_tuser, req_tdata[ValW-1:0], req_tdata[ValW +: SlotW],
                               req_tdata[ValW+SlotW +: SlotW]);
            pending_replies.push_back(want);
            case (want.status)
               STAT_OK:    ok_seen++;
               STAT_FULL:  full_seen++;
               STAT_EMPTY: empty_seen++;
               default:    invalid_seen++;
            endcase
         end
      end
      pending_count = pending_replies.size();
   end

endmodule

### sim/array_linked_list_engine_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for array_linked_list_engine_unit: drives list requests with random
// idling on both streams and gives the verdict. Depends on alle_pkg, alle_list_checker.

module array_linked_list_engine_unit_test;
   import alle_pkg::*;

   localparam int ItemTarget  = 1600;
   localparam int CalmItems   = 160;
   localparam int LimitCycles = 900_000;

   typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_kind_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;  // value[31:0], rank[37:32], slot[43:38], zero pad
   logic [2:0]          req_tuser  = '0;  // mode[2:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [RspDataW-1:0] rsp_tdata;        // removed_value[31:0], used_slot[37:32], zero pad
   logic [1:0]          rsp_tuser;        // status[1:0]

   logic             req_taken = 1'b0;
   logic             calm      = 1'b0;
   int               gap_pct   = 20;
   int               stall_pct = 20;
   int               rsp_hold  = 0;
   int               sent_count;
   int               cycle_count;
   int               fail_count;
   int               pending_count;
   int               live_count;
   int               ok_seen, full_seen, empty_seen, invalid_seen;
   logic [Depth-1:0] live_slots;

   array_linked_list_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   alle_list_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .live_slots    (live_slots),
      .live_count    (live_count),
      .ok_seen       (ok_seen),
      .full_seen     (full_seen),
      .empty_seen    (empty_seen),
      .invalid_seen  (invalid_seen)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      cycle_count++;
      if (cycle_count == LimitCycles) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending_count);
         $display("array_linked_list_engine_unit_test: done, errors");
         $finish;
      end
   end

   // reply-side backpressure in bursts
   always @(negedge clock) begin
      if (reset || calm || stall_pct == 0) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if ($urandom_range(99, 0) < stall_pct) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= $urandom_range(13, 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // called and returns at a falling edge
   task automatic send_req(input logic [2:0] mode, input logic [ValW-1:0] value,
                           input logic [SlotW-1:0] rank, input logic [SlotW-1:0] slot);
      if (!calm && $urandom_range(99, 0) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, slot, rank, value};
      do @(negedge clock); while (!req_taken);
      sent_count++;
   endtask

   // always waits for a falling edge so valid is never dropped and raised in one step
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   initial begin
      phase_kind_type   phase;
      int               phase_len;
      int               pick;
      int               start;
      int               idx;
      logic [2:0]       mode;
      logic [ValW-1:0]  value;
      logic [SlotW-1:0] rank;
      logic [SlotW-1:0] slot;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty-list errors, value extremes, head/tail insert, bad rank and slot
      send_req(MODE_CLEAR,  32'h0000_0000, 6'd0,  6'd0);
      send_req(MODE_POP,    32'h0000_0000, 6'd0,  6'd0);
      send_req(MODE_DELETE, 32'h0000_0000, 6'd0,  6'd0);
      send_req(MODE_INSERT, 32'h1111_1111, 6'd1,  6'd0);
      send_req(MODE_APPEND, 32'h7FFF_FFFF, 6'd0,  6'd0);
      send_req(MODE_APPEND, 32'h8000_0000, 6'd0,  6'd0);
      send_req(MODE_APPEND, 32'hFFFF_FFFF, 6'd0,  6'd0);
      send_req(MODE_INSERT, 32'h0000_0000, 6'd0,  6'd0);
      send_req(MODE_INSERT, 32'h5A5A_5A5A, 6'd4,  6'd0);
      send_req(MODE_INSERT, 32'h2222_2222, 6'd63, 6'd0);
      send_req(MODE_DELETE, 32'h0000_0000, 6'd0,  6'd0);
      send_req(MODE_DELETE, 32'h0000_0000, 6'd0,  6'd63);
      send_req(MODE_DELETE, 32'h0000_0000, 6'd0,  6'd2);
      send_req(MODE_APPEND, 32'h1234_5678, 6'd0,  6'd0);
      send_req(MODE_POP,    32'h0000_0000, 6'd0,  6'd0);
      send_req(3'd5,        32'hFFFF_FFFF, 6'd63, 6'd63);
      send_req(3'd6,        32'h0000_0000, 6'd0,  6'd0);
      send_req(3'd7,        32'hFFFF_FFFF, 6'd63, 6'd63);
      send_req(MODE_INSERT, 32'hA5A5_A5A5, 6'd2,  6'd0);
      send_req(MODE_DELETE, 32'h0000_0000, 6'd0,  6'd4);
      send_req(MODE_CLEAR,  32'h0000_0000, 6'd0,  6'd0);
      send_req(MODE_POP,    32'h0000_0000, 6'd0,  6'd0);
      send_req(MODE_DELETE, 32'h0000_0000, 6'd0,  6'd1);
      send_req(MODE_APPEND, 32'h0000_0001, 6'd0,  6'd0);
      wait_drained();

      // random: runs biased toward filling, draining or mixing, plus raw noise
      while (sent_count < ItemTarget) begin
         pick      = $urandom_range(99, 0);
         phase     = (pick < 35) ? PH_FILL : (pick < 60) ? PH_DRAIN :
                     (pick < 90) ? PH_MIXED : PH_NOISE;
         phase_len = (phase == PH_FILL) ? $urandom_range(140, 60) : $urandom_range(80, 20);
         case ($urandom_range(3, 0))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            2:       gap_pct = 30;
            default: gap_pct = 60;
         endcase
         case ($urandom_range(3, 0))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 30;
            default: stall_pct = 60;
         endcase
         if (!calm && $urandom_range(5, 0) == 0) wait_drained();

         repeat (phase_len) begin
            if (sent_count >= ItemTarget) break;
            if (sent_count >= ItemTarget - CalmItems) calm = 1'b1;

            pick  = $urandom_range(99, 0);
            value = $urandom;
            if ($urandom_range(9, 0) == 0) begin
               case ($urandom_range(3, 0))
                  0:       value = 32'h7FFF_FFFF;
                  1:       value = 32'h8000_0000;
                  2:       value = '0;
                  default: value = '1;
               endcase
            end
            rank = ($urandom_range(9, 0) != 0) ? SlotW'($urandom_range(live_count, 0))
                                                : SlotW'($urandom);
            slot = SlotW'($urandom);
            if (live_count > 0 && $urandom_range(9, 0) != 0) begin
               start = $urandom_range(Depth - 1, 1);
               for (int k = 0; k < Depth; k++) begin
                  idx = (start + k) % Depth;
                  if (idx != 0 && live_slots[idx]) begin
                     slot = SlotW'(idx);
                     break;
                  end
               end
            end

            case (phase)
               PH_FILL:  mode = (pick < 50) ? MODE_APPEND : (pick < 94) ? MODE_INSERT :
                                (pick < 97) ? MODE_POP : MODE_DELETE;
               PH_DRAIN: mode = (pick < 40) ? MODE_POP : (pick < 90) ? MODE_DELETE :
                                (pick < 96) ? MODE_APPEND : MODE_INSERT;
               PH_MIXED: mode = (pick < 30) ? MODE_APPEND : (pick < 55) ? MODE_INSERT :
                                (pick < 75) ? MODE_POP : (pick < 97) ? MODE_DELETE : MODE_CLEAR;
               default: begin
                  mode = 3'($urandom);
                  rank = SlotW'($urandom);
                  slot = SlotW'($urandom);
               end
            endcase
            send_req(mode, value, rank, slot);
         end
      end

      wait_drained();
      repeat (80) @(negedge clock);

      $display("covered %0d requests in %0d cycles, list filled and emptied repeatedly",
               sent_count, cycle_count);
      $display("reply status mix: %0d ok, %0d full, %0d empty, %0d invalid",
               ok_seen, full_seen, empty_seen, invalid_seen);
      if (fail_count == 0) begin
         $display("array_linked_list_engine_unit_test: done, clean");
      end else begin
         $display("array_linked_list_engine_unit_test: done, errors");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/alle_pkg.sv
hw/rtl/alle_ram.sv
hw/rtl/alle_slot_map.sv
hw/rtl/array_linked_list_engine_unit.sv
sim/alle_list_checker.sv
sim/array_linked_list_engine_unit_test.sv
